FILE: rtl/owt_pkg.sv
// Shared types, constants and a helper function for the one-wire temperature read block.
`timescale 1ns / 1ps
`default_nettype none

package owt_pkg;

    localparam int TIMER_W    = 20;
    localparam int SHORT_W    = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int PHASE_W    = 4;
    localparam int TEMP_W     = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRES_SAMPLE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POST_RESET   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_HOLD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_RECOVER = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CONVERSION   = 3'd6;

    // Reset values of the timing registers, in microsecond ticks.
    localparam logic [SHORT_W-1:0] RST_RESET_LOW    = 10'd450;
    localparam logic [SHORT_W-1:0] RST_PRES_SAMPLE  = 10'd15;
    localparam logic [TIMER_W-1:0] RST_POST_RESET   = 20'd100000;
    localparam logic [SHORT_W-1:0] RST_WRITE_HOLD   = 10'd21;
    localparam logic [SHORT_W-1:0] RST_READ_SAMPLE  = 10'd7;
    localparam logic [SHORT_W-1:0] RST_READ_RECOVER = 10'd25;
    localparam logic [TIMER_W-1:0] RST_CONVERSION   = 20'd750000;

    // Bus commands.
    localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;
    localparam logic [7:0] CMD_CONVERT    = 8'h44;
    localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;

    // Sequencer phase codes.
    localparam logic [PHASE_W-1:0] PH_IDLE     = 4'd0;
    localparam logic [PHASE_W-1:0] PH_PRE_HIGH = 4'd1;
    localparam logic [PHASE_W-1:0] PH_RST_LOW  = 4'd2;
    localparam logic [PHASE_W-1:0] PH_PRESENCE = 4'd3;
    localparam logic [PHASE_W-1:0] PH_POST_RST = 4'd4;
    localparam logic [PHASE_W-1:0] PH_WR_START = 4'd5;
    localparam logic [PHASE_W-1:0] PH_WR_HOLD  = 4'd6;
    localparam logic [PHASE_W-1:0] PH_WR_REL   = 4'd7;
    localparam logic [PHASE_W-1:0] PH_RD_START = 4'd8;
    localparam logic [PHASE_W-1:0] PH_RD_SAMP  = 4'd9;
    localparam logic [PHASE_W-1:0] PH_RD_REC   = 4'd10;
    localparam logic [PHASE_W-1:0] PH_CONVERT  = 4'd11;

    typedef struct packed {
        logic [SHORT_W-1:0] reset_low_ticks;
        logic [SHORT_W-1:0] presence_sample_ticks;
        logic [TIMER_W-1:0] post_reset_ticks;
        logic [SHORT_W-1:0] write_hold_ticks;
        logic [SHORT_W-1:0] read_sample_ticks;
        logic [SHORT_W-1:0] read_recover_ticks;
        logic [TIMER_W-1:0] conversion_ticks;
    } timing_cfg_t;

    typedef struct packed {
        logic              drive_low;
        logic              busy_res;
        logic              done_res;
        logic              success;
        logic [TEMP_W-1:0] temperature_raw;
    } result_t;

    // Command byte sent at each step of the command sequence.
    function automatic logic [7:0] cmd_byte(input logic [2:0] step);
        logic [7:0] b;
        b = 8'h00;
        case (step)
            3'd0, 3'd2: b = CMD_SKIP_ROM;
            3'd1:       b = CMD_CONVERT;
            3'd3:       b = CMD_READ_SCRATCH;
            default:    b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/owt_if.sv
// Valid/ready channel interfaces for tick items and result items.
`timescale 1ns / 1ps
`default_nettype none

interface owt_tick_if;
    logic valid;
    logic ready;
    logic start_req;
    logic line_level;

    modport source (output valid, output start_req, output line_level, input ready);
    modport sink   (input valid, input start_req, input line_level, output ready);
endinterface

interface owt_result_if;
    logic        valid;
    logic        ready;
    logic        drive_low;
    logic        busy_res;
    logic        done_res;
    logic        success;
    logic [15:0] temperature_raw;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output success, output temperature_raw, input ready);
    modport sink   (input valid, input drive_low, input busy_res, input done_res,
                    input success, input temperature_raw, output ready);
endinterface

`default_nettype wire

FILE: rtl/owt_cfg_regs.sv
// Timing configuration registers with their write decoder.
`timescale 1ns / 1ps
`default_nettype none

module owt_cfg_regs
    import owt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output timing_cfg_t                timing
);

    timing_cfg_t timing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg.reset_low_ticks       <= RST_RESET_LOW;
            timing_reg.presence_sample_ticks <= RST_PRES_SAMPLE;
            timing_reg.post_reset_ticks      <= RST_POST_RESET;
            timing_reg.write_hold_ticks      <= RST_WRITE_HOLD;
            timing_reg.read_sample_ticks     <= RST_READ_SAMPLE;
            timing_reg.read_recover_ticks    <= RST_READ_RECOVER;
            timing_reg.conversion_ticks      <= RST_CONVERSION;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RESET_LOW:    timing_reg.reset_low_ticks       <= cfg_data[SHORT_W-1:0];
                CFG_PRES_SAMPLE:  timing_reg.presence_sample_ticks <= cfg_data[SHORT_W-1:0];
                CFG_POST_RESET:   timing_reg.post_reset_ticks      <= cfg_data[TIMER_W-1:0];
                CFG_WRITE_HOLD:   timing_reg.write_hold_ticks      <= cfg_data[SHORT_W-1:0];
                CFG_READ_SAMPLE:  timing_reg.read_sample_ticks     <= cfg_data[SHORT_W-1:0];
                CFG_READ_RECOVER: timing_reg.read_recover_ticks    <= cfg_data[SHORT_W-1:0];
                CFG_CONVERSION:   timing_reg.conversion_ticks      <= cfg_data[TIMER_W-1:0];
                default:          ;
            endcase
        end
    end

    assign timing = timing_reg;

endmodule

`default_nettype wire

FILE: rtl/owt_seq.sv
// Bus sequencer: phase, timer and shift state, advanced once per accepted tick.
`timescale 1ns / 1ps
`default_nettype none

module owt_seq
    import owt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  advance,
    input  wire logic  start_req,
    input  wire logic  line_level,
    input  timing_cfg_t timing,
    output result_t    result
);

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [TIMER_W-1:0] timer_reg, timer_next;
    logic [2:0]         bit_reg, bit_next;
    logic [2:0]         step_reg, step_next;
    logic [7:0]         shift_reg, shift_next;
    logic [TEMP_W-1:0]  hold_reg, hold_next;
    logic               ok_reg, ok_next;

    logic [TIMER_W-1:0] wait_len;
    logic [TIMER_W-1:0] samp_len;
    logic [TIMER_W:0]   timer_inc;
    logic               wait_hit;
    logic               samp_hit;
    logic [2:0]         bit_inc;
    logic               drive;
    logic               done;

    // Length of the plain wait or sampling wait that the current phase uses.
    always_comb
    begin
        wait_len = timing.post_reset_ticks;
        samp_len = TIMER_W'(timing.presence_sample_ticks);
        case (phase_reg)
            PH_PRE_HIGH: wait_len = TIMER_W'(timing.presence_sample_ticks);
            PH_RST_LOW:  wait_len = TIMER_W'(timing.reset_low_ticks);
            PH_WR_HOLD:  wait_len = TIMER_W'(timing.write_hold_ticks);
            PH_RD_REC:   wait_len = TIMER_W'(timing.read_recover_ticks);
            PH_CONVERT:  wait_len = timing.conversion_ticks;
            default:     wait_len = timing.post_reset_ticks;
        endcase
        if (phase_reg == PH_RD_SAMP)
        begin
            samp_len = TIMER_W'(timing.read_sample_ticks);
        end
    end

    assign timer_inc = {1'b0, timer_reg} + (TIMER_W+1)'(1);
    assign wait_hit  = timer_inc >= {1'b0, wait_len};
    assign samp_hit  = timer_reg >= samp_len;
    assign bit_inc   = bit_reg + 3'd1;

    always_comb
    begin
        phase_next = phase_reg;
        timer_next = timer_reg;
        bit_next   = bit_reg;
        step_next  = step_reg;
        shift_next = shift_reg;
        hold_next  = hold_reg;
        ok_next    = ok_reg;
        drive      = 1'b0;
        done       = 1'b0;

        unique case (phase_reg) inside
            PH_PRE_HIGH, PH_RST_LOW, PH_POST_RST, PH_CONVERT:
            begin
                drive = (phase_reg == PH_RST_LOW);
                if (wait_hit)
                begin
                    timer_next = '0;
                    case (phase_reg)
                        PH_PRE_HIGH: phase_next = PH_RST_LOW;
                        PH_RST_LOW:  phase_next = PH_PRESENCE;
                        PH_CONVERT:  phase_next = PH_PRE_HIGH;
                        default:
                        begin
                            shift_next = cmd_byte(step_reg);
                            bit_next   = 3'd0;
                            phase_next = PH_WR_START;
                        end
                    endcase
                end
                else
                begin
                    timer_next = timer_inc[TIMER_W-1:0];
                end
            end
            PH_PRESENCE:
            begin
                if (samp_hit)
                begin
                    timer_next = '0;
                    if (line_level)
                    begin
                        done       = 1'b1;
                        ok_next    = 1'b0;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_POST_RST;
                    end
                end
                else
                begin
                    timer_next = timer_inc[TIMER_W-1:0];
                end
            end
            PH_WR_START, PH_RD_START:
            begin
                drive      = 1'b1;
                timer_next = '0;
                phase_next = (phase_reg == PH_WR_START) ? PH_WR_HOLD : PH_RD_SAMP;
            end
            PH_WR_HOLD:
            begin
                drive = ~shift_reg[0];
                if (wait_hit)
                begin
                    timer_next = '0;
                    phase_next = PH_WR_REL;
                end
                else
                begin
                    timer_next = timer_inc[TIMER_W-1:0];
                end
            end
            PH_WR_REL:
            begin
                shift_next = {1'b0, shift_reg[7:1]};
                bit_next   = bit_inc;
                timer_next = '0;
                if (bit_inc != 3'd0)
                begin
                    phase_next = PH_WR_START;
                end
                else if (step_reg == 3'd1)
                begin
                    step_next  = 3'd2;
                    phase_next = PH_CONVERT;
                end
                else if (step_reg >= 3'd3)
                begin
                    step_next  = 3'd4;
                    bit_next   = 3'd0;
                    shift_next = 8'h00;
                    phase_next = PH_RD_START;
                end
                else
                begin
                    step_next  = step_reg + 3'd1;
                    shift_next = cmd_byte(step_reg + 3'd1);
                    bit_next   = 3'd0;
                    phase_next = PH_WR_START;
                end
            end
            PH_RD_SAMP:
            begin
                if (samp_hit)
                begin
                    timer_next = '0;
                    shift_next = {line_level, shift_reg[7:1]};
                    phase_next = PH_RD_REC;
                end
                else
                begin
                    timer_next = timer_inc[TIMER_W-1:0];
                end
            end
            PH_RD_REC:
            begin
                if (wait_hit)
                begin
                    timer_next = '0;
                    bit_next   = bit_inc;
                    if (bit_inc != 3'd0)
                    begin
                        phase_next = PH_RD_START;
                    end
                    else if (step_reg == 3'd4)
                    begin
                        hold_next  = {hold_reg[15:8], shift_reg};
                        step_next  = 3'd5;
                        shift_next = 8'h00;
                        phase_next = PH_RD_START;
                    end
                    else
                    begin
                        hold_next  = {shift_reg, hold_reg[7:0]};
                        done       = 1'b1;
                        ok_next    = 1'b1;
                        phase_next = PH_IDLE;
                    end
                end
                else
                begin
                    timer_next = timer_inc[TIMER_W-1:0];
                end
            end
            default:
            begin
                // Idle, and any code outside the sequence falls back to idle.
                phase_next = PH_IDLE;
                if (start_req)
                begin
                    timer_next = '0;
                    bit_next   = 3'd0;
                    step_next  = 3'd0;
                    shift_next = 8'h00;
                    ok_next    = 1'b0;
                    phase_next = PH_PRE_HIGH;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            timer_reg <= '0;
            bit_reg   <= '0;
            step_reg  <= '0;
            shift_reg <= '0;
            hold_reg  <= '0;
            ok_reg    <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            bit_reg   <= bit_next;
            step_reg  <= step_next;
            shift_reg <= shift_next;
            hold_reg  <= hold_next;
            ok_reg    <= ok_next;
        end
    end

    assign result.drive_low       = drive;
    assign result.busy_res        = (phase_next != PH_IDLE);
    assign result.done_res        = done;
    assign result.success         = done & ok_next;
    assign result.temperature_raw = (done && ok_next) ? hold_next : '0;

endmodule

`default_nettype wire

FILE: rtl/one_wire_temperature_read.sv
// Top level of the one-wire temperature read block.
`timescale 1ns / 1ps
`default_nettype none

// One-wire bus master that reads a temperature sensor. Each tick transaction carries a
// start request and the sampled bus level for one microsecond; it yields exactly one
// result transaction with the line drive, busy and done flags, and on a successful done
// the 16-bit raw temperature. The full sequence is reset and presence, skip ROM and
// convert, conversion wait, a second reset and presence, skip ROM and read scratchpad,
// then two read bytes. One tick is accepted every clock cycle while the output register
// is empty or its waiting result is taken in that cycle; a tick's result appears in the
// output register on the next cycle. The user must write the timing registers through
// the configuration port only while the bus is idle; the block does not enforce this.

module one_wire_temperature_read
    import owt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    owt_tick_if.sink                   tick,
    owt_result_if.source               result,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    timing_cfg_t timing;
    result_t     seq_result;
    result_t     out_reg;
    logic        out_valid_reg;
    logic        accept;

    owt_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .timing    (timing)
    );

    assign tick.ready = ~out_valid_reg | result.ready;
    assign accept     = tick.valid & tick.ready;

    owt_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (accept),
        .start_req  (tick.start_req),
        .line_level (tick.line_level),
        .timing     (timing),
        .result     (seq_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= seq_result;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.drive_low       = out_reg.drive_low;
    assign result.busy_res        = out_reg.busy_res;
    assign result.done_res        = out_reg.done_res;
    assign result.success         = out_reg.success;
    assign result.temperature_raw = out_reg.temperature_raw;

endmodule

`default_nettype wire

FILE: rtl/owt_checker.sv
// Port-level assertions for the one-wire temperature read block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module owt_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        res_valid,
    input wire logic        res_ready,
    input wire logic        drive_low,
    input wire logic        busy_res,
    input wire logic        done_res,
    input wire logic        success,
    input wire logic [15:0] temperature_raw
);

    // A result that is not taken stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result withdrawn while stalled");

    // A finished transaction is no longer busy.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && done_res |-> !busy_res)
        else $error("done reported while still busy");

    // Success is only reported together with done.
    a_success_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && success |-> done_res)
        else $error("success without done");

    // The temperature field is zero unless a read succeeded.
    a_temp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !success |-> temperature_raw == 16'h0000)
        else $error("temperature shown without success");

    // The line is never pulled low on the tick a transaction ends.
    a_done_released: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && done_res |-> !drive_low)
        else $error("line driven on the done tick");

endmodule

bind one_wire_temperature_read owt_checker u_owt_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (result.valid),
    .res_ready       (result.ready),
    .drive_low       (result.drive_low),
    .busy_res        (result.busy_res),
    .done_res        (result.done_res),
    .success         (result.success),
    .temperature_raw (result.temperature_raw)
);

`default_nettype wire

FILE: dv/one_wire_temperature_read_test.sv
// Self-checking testbench for the one-wire temperature read sequencer.
`timescale 1ns / 1ps

module one_wire_temperature_read_test;
    import owt_pkg::*;

    localparam int IDLE_PCT          = 12;
    localparam int HOLD_CYCLES       = 300;
    localparam int SETTLE_CYCLES     = 4;
    localparam int RANDOM_READ_TICKS = 250;
    localparam int REPORT_CAP        = 100;
    localparam int CYCLE_LIMIT       = 50000;

    localparam logic [31:0] COMMAND_SEQ =
        {CMD_READ_SCRATCH, CMD_SKIP_ROM, CMD_CONVERT, CMD_SKIP_ROM};

    typedef enum {SENSOR_PRESENT, SENSOR_MISSING, SENSOR_LOST, SENSOR_FLAKY} sensor_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    owt_tick_if   tick_ch ();
    owt_result_if result_ch ();

    one_wire_temperature_read u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predicted sequencer state and timing registers.
    logic [PHASE_W-1:0] seq_phase;
    logic [TIMER_W-1:0] seq_timer;
    logic [2:0]         seq_bit;
    logic [2:0]         seq_step;
    logic [7:0]         seq_shift;
    logic [TEMP_W-1:0]  seq_temp;
    logic               seq_success;
    timing_cfg_t        timing;

    result_t pending_bus_results[$];
    int      mismatch_count;
    int      read_ticks;
    int      cycle_count;
    int      sink_hold_cycles;
    bit      sender_idling;
    bit      sink_idling;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string field, input logic [15:0] want_v,
                                   input logic [15:0] got_v);
        if (mismatch_count < REPORT_CAP)
            $display("%0t: %s expected %h got %h", $time, field, want_v, got_v);
        mismatch_count++;
    endtask

    // Plain wait of n ticks, where zero still takes one tick.
    function automatic logic wait_elapsed(input logic [TIMER_W-1:0] n);
        if ({1'b0, seq_timer} + 21'd1 >= {1'b0, n})
        begin
            seq_timer = '0;
            return 1'b1;
        end
        seq_timer = seq_timer + 20'd1;
        return 1'b0;
    endfunction

    // Wait of n ticks followed by the sample tick.
    function automatic logic sample_due(input logic [TIMER_W-1:0] n);
        if (seq_timer >= n)
        begin
            seq_timer = '0;
            return 1'b1;
        end
        seq_timer = seq_timer + 20'd1;
        return 1'b0;
    endfunction

    function automatic void load_command();
        seq_shift = (seq_step < 3'd4) ? COMMAND_SEQ[8*seq_step[1:0] +: 8] : 8'h00;
        seq_bit   = '0;
        seq_phase = PH_WR_START;
    endfunction

    task automatic advance_bus_sequence(input logic start, input logic level,
                                        output result_t r);
        logic drive;
        logic done;
        drive = 1'b0;
        done  = 1'b0;
        case (seq_phase)
            PH_PRE_HIGH:
                if (wait_elapsed(timing.presence_sample_ticks)) seq_phase = PH_RST_LOW;
            PH_RST_LOW:
            begin
                drive = 1'b1;
                if (wait_elapsed(timing.reset_low_ticks)) seq_phase = PH_PRESENCE;
            end
            PH_PRESENCE:
                if (sample_due(timing.presence_sample_ticks))
                begin
                    if (level)
                    begin
                        done        = 1'b1;
                        seq_success = 1'b0;
                        seq_phase   = PH_IDLE;
                    end
                    else
                        seq_phase = PH_POST_RST;
                end
            PH_POST_RST:
                if (wait_elapsed(timing.post_reset_ticks)) load_command();
            PH_WR_START:
            begin
                drive     = 1'b1;
                seq_timer = '0;
                seq_phase = PH_WR_HOLD;
            end
            PH_WR_HOLD:
            begin
                drive = ~seq_shift[0];
                if (wait_elapsed(timing.write_hold_ticks)) seq_phase = PH_WR_REL;
            end
            PH_WR_REL:
            begin
                seq_shift = seq_shift >> 1;
                seq_bit   = seq_bit + 3'd1;
                seq_timer = '0;
                if (seq_bit != 3'd0)
                    seq_phase = PH_WR_START;
                else if (seq_step == 3'd1)
                begin
                    seq_step  = 3'd2;
                    seq_phase = PH_CONVERT;
                end
                else if (seq_step >= 3'd3)
                begin
                    seq_step  = 3'd4;
                    seq_bit   = '0;
                    seq_shift = '0;
                    seq_phase = PH_RD_START;
                end
                else
                begin
                    seq_step = seq_step + 3'd1;
                    load_command();
                end
            end
            PH_CONVERT:
                if (wait_elapsed(timing.conversion_ticks)) seq_phase = PH_PRE_HIGH;
            PH_RD_START:
            begin
                drive     = 1'b1;
                seq_timer = '0;
                seq_phase = PH_RD_SAMP;
            end
            PH_RD_SAMP:
                if (sample_due(timing.read_sample_ticks))
                begin
                    seq_shift = {level, seq_shift[7:1]};
                    seq_phase = PH_RD_REC;
                end
            PH_RD_REC:
                if (wait_elapsed(timing.read_recover_ticks))
                begin
                    seq_bit = seq_bit + 3'd1;
                    if (seq_bit != 3'd0)
                        seq_phase = PH_RD_START;
                    else if (seq_step == 3'd4)
                    begin
                        seq_temp[7:0] = seq_shift;
                        seq_step      = 3'd5;
                        seq_shift     = '0;
                        seq_phase     = PH_RD_START;
                    end
                    else
                    begin
                        seq_temp[15:8] = seq_shift;
                        done           = 1'b1;
                        seq_success    = 1'b1;
                        seq_phase      = PH_IDLE;
                    end
                end
            default:
            begin
                seq_phase = PH_IDLE;
                if (start)
                begin
                    seq_timer   = '0;
                    seq_bit     = '0;
                    seq_step    = '0;
                    seq_shift   = '0;
                    seq_success = 1'b0;
                    seq_phase   = PH_PRE_HIGH;
                end
            end
        endcase
        r.drive_low       = drive;
        r.busy_res        = (seq_phase != PH_IDLE);
        r.done_res        = done;
        r.success         = done & seq_success;
        r.temperature_raw = (done && seq_success) ? seq_temp : '0;
    endtask

    // Called right after a rising edge; returns at the edge that accepts the tick.
    task automatic send_tick(input logic start, input logic level);
        result_t want;
        if (sender_idling && $urandom_range(0, 99) < IDLE_PCT)
        begin
            tick_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        tick_ch.valid      <= 1'b1;
        tick_ch.start_req  <= start;
        tick_ch.line_level <= level;
        @(posedge clk);
        while (!tick_ch.ready) @(posedge clk);
        advance_bus_sequence(start, level, want);
        pending_bus_results.push_back(want);
    endtask

    task automatic drain_results();
        tick_ch.valid <= 1'b0;
        while (pending_bus_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Short registers get random upper data bits, which the block must drop.
    task automatic program_timing(input timing_cfg_t c);
        logic [9:0] pad;
        pad = 10'($urandom_range(0, 1023));
        set_register(CFG_RESET_LOW, {pad, c.reset_low_ticks});
        set_register(CFG_PRES_SAMPLE, {~pad, c.presence_sample_ticks});
        set_register(CFG_POST_RESET, c.post_reset_ticks);
        set_register(CFG_WRITE_HOLD, {pad, c.write_hold_ticks});
        set_register(CFG_READ_SAMPLE, {~pad, c.read_sample_ticks});
        set_register(CFG_READ_RECOVER, {pad, c.read_recover_ticks});
        set_register(CFG_CONVERSION, c.conversion_ticks);
        cfg_we <= 1'b0;
        timing = c;
    endtask

    // Plays the sensor for one full read. Outside the sample ticks the line is noise.
    task automatic run_read(input logic [15:0] word, input sensor_mode_t mode,
                            input int pause_after);
        int   presence_seen;
        int   sent;
        logic level;
        presence_seen = 0;
        sent = 1;
        send_tick(1'b1, 1'($urandom_range(0, 1)));
        while (seq_phase != PH_IDLE)
        begin
            level = 1'($urandom_range(0, 1));
            if (seq_phase == PH_PRESENCE && seq_timer >= timing.presence_sample_ticks)
            begin
                presence_seen++;
                case (mode)
                    SENSOR_PRESENT: level = 1'b0;
                    SENSOR_MISSING: level = 1'b1;
                    SENSOR_LOST:    level = (presence_seen == 2);
                    default:        level = ($urandom_range(0, 99) < 15);
                endcase
            end
            else if (seq_phase == PH_RD_SAMP && seq_timer >= timing.read_sample_ticks)
                level = (seq_step == 3'd4) ? word[{1'b0, seq_bit}] : word[{1'b1, seq_bit}];
            if (sent == pause_after)
                drain_results();
            send_tick(1'($urandom_range(0, 1)), level);
            sent++;
        end
        read_ticks += sent;
    endtask

    function automatic logic [TIMER_W-1:0] brief_ticks();
        return TIMER_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 24)
                                                    : $urandom_range(0, 2));
    endfunction

    function automatic timing_cfg_t random_timing();
        timing_cfg_t c;
        c.reset_low_ticks       = SHORT_W'(brief_ticks());
        c.presence_sample_ticks = SHORT_W'(brief_ticks());
        c.post_reset_ticks      = brief_ticks();
        c.write_hold_ticks      = SHORT_W'(brief_ticks());
        c.read_sample_ticks     = SHORT_W'(brief_ticks());
        c.read_recover_ticks    = SHORT_W'(brief_ticks());
        c.conversion_ticks      = brief_ticks();
        return c;
    endfunction

    // Reset values: only a failed presence fits in the run at these timings.
    task automatic test_default_timing();
        send_tick(1'b0, 1'b1);
        run_read(16'($urandom_range(0, 65535)), SENSOR_MISSING, 0);
        drain_results();
    endtask

    task automatic test_zero_timing();
        timing_cfg_t c;
        c = '{10'd0, 10'd0, 20'd0, 10'd0, 10'd0, 10'd0, 20'd0};
        program_timing(c);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        run_read(16'hA53C, SENSOR_PRESENT, 0);
        run_read(16'($urandom_range(0, 65535)), SENSOR_MISSING, 0);
        run_read(16'($urandom_range(0, 65535)), SENSOR_LOST, 0);
        send_tick(1'b0, 1'b1);
        drain_results();
    endtask

    // A whole read with no idling on either side.
    task automatic test_steady_stream();
        timing_cfg_t c;
        c = '{10'd3, 10'd1, 20'd20, 10'd1, 10'd0, 10'd1, 20'd30};
        program_timing(c);
        sender_idling = 1'b0;
        sink_idling   = 1'b0;
        run_read(16'($urandom_range(0, 65535)), SENSOR_PRESENT, 0);
        sender_idling = 1'b1;
        sink_idling   = 1'b1;
        drain_results();
    endtask

    task automatic test_backpressure();
        timing_cfg_t c;
        c = '{10'd2, 10'd2, 20'd2, 10'd2, 10'd2, 10'd2, 20'd2};
        program_timing(c);
        sink_hold_cycles = HOLD_CYCLES;
        run_read(16'($urandom_range(0, 65535)), SENSOR_PRESENT, 80);
        drain_results();
    endtask

    task automatic test_random_reads();
        int           first_ticks;
        int           pick;
        sensor_mode_t mode;
        first_ticks = read_ticks;
        while (read_ticks - first_ticks < RANDOM_READ_TICKS)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                drain_results();
                program_timing(random_timing());
            end
            pick = $urandom_range(0, 99);
            if (pick < 10)
                repeat ($urandom_range(1, 8)) send_tick(1'b0, 1'($urandom_range(0, 1)));
            else
            begin
                if (pick < 78)
                    mode = SENSOR_PRESENT;
                else if (pick < 86)
                    mode = SENSOR_MISSING;
                else if (pick < 93)
                    mode = SENSOR_LOST;
                else
                    mode = SENSOR_FLAKY;
                run_read(16'($urandom_range(0, 65535)), mode, 0);
            end
        end
        drain_results();
    endtask

    // Result sink with random stalls and an occasional long hold-off.
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_hold_cycles > 0)
            begin
                result_ch.ready <= 1'b0;
                sink_hold_cycles--;
            end
            else
                result_ch.ready <= !(sink_idling && $urandom_range(0, 99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_bus_results.size() == 0)
                report_mismatch("unexpected result, temperature_raw", 16'h0,
                                result_ch.temperature_raw);
            else
            begin
                want = pending_bus_results.pop_front();
                if (result_ch.drive_low !== want.drive_low)
                    report_mismatch("drive_low", 16'(want.drive_low),
                                    16'(result_ch.drive_low));
                if (result_ch.busy_res !== want.busy_res)
                    report_mismatch("busy_res", 16'(want.busy_res),
                                    16'(result_ch.busy_res));
                if (result_ch.done_res !== want.done_res)
                    report_mismatch("done_res", 16'(want.done_res),
                                    16'(result_ch.done_res));
                if (result_ch.success !== want.success)
                    report_mismatch("success", 16'(want.success), 16'(result_ch.success));
                if (result_ch.temperature_raw !== want.temperature_raw)
                    report_mismatch("temperature_raw", want.temperature_raw,
                                    result_ch.temperature_raw);
            end
        end
    end

    initial
    begin
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= '0;
        cfg_data           <= '0;
        tick_ch.valid      <= 1'b0;
        tick_ch.start_req  <= 1'b0;
        tick_ch.line_level <= 1'b0;
        mismatch_count   = 0;
        read_ticks       = 0;
        cycle_count      = 0;
        sink_hold_cycles = 0;
        sender_idling    = 1'b1;
        sink_idling      = 1'b1;
        seq_phase   = PH_IDLE;
        seq_timer   = '0;
        seq_bit     = '0;
        seq_step    = '0;
        seq_shift   = '0;
        seq_temp    = '0;
        seq_success = 1'b0;
        timing = '{RST_RESET_LOW, RST_PRES_SAMPLE, RST_POST_RESET, RST_WRITE_HOLD,
                   RST_READ_SAMPLE, RST_READ_RECOVER, RST_CONVERSION};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_timing();
        test_zero_timing();
        test_steady_stream();
        test_backpressure();
        test_random_reads();

        drain_results();
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
